[rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define HRP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HRP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hrp_pkg.sv]
package hrp_pkg;

  localparam int DEF_MAX_HEADERS = 16;
  localparam int DEF_MAX_LENGTH  = 4096;

  // result beat width: 87 payload bits padded to whole bytes
  localparam int RES_BITS = 88;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;

  // accept prefix tracker codes
  localparam logic [3:0] ACC_DONE = 4'd8;
  localparam logic [3:0] ACC_FAIL = 4'd15;

  localparam logic [2:0] TOK_SAT = 3'd7;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_LINE,
    PH_HEADERS,
    PH_CLOSED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_METHOD,
    ST_CRLF,
    ST_LONG
  } status_t;

  localparam logic [2:0] M_NONE = 3'd0;

  localparam logic [2:0] METHOD_LEN [7] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7};

  localparam logic [7:0] METHOD_CHARS [7][8] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E",   "T",   "E",   8'h00, 8'h00},
    '{"T", "R", "A", "C",   "E",   8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N",   "E",   "C",   "T",   8'h00}
  };

  localparam logic [7:0] ACCEPT_CHARS [8] = '{"A", "c", "c", "e", "p", "t", ":", " "};

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  method;
    logic [11:0] uri_start;
    logic [12:0] uri_len;
    logic        ver_present;
    logic [11:0] ver_start;
    logic [12:0] ver_len;
    logic [11:0] acc_start;
    logic [12:0] acc_len;
  } saved_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  method_code;
    logic [11:0] uri_start;
    logic [12:0] uri_length;
    logic        version_present;
    logic [11:0] version_start;
    logic [12:0] version_length;
    logic [4:0]  header_count;
    logic        accept_present;
    logic [11:0] accept_start;
    logic [12:0] accept_length;
  } result_t;

endpackage

[rtl/hrp_in_stage.sv]
module hrp_in_stage
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       take,
  output in_beat_t   beat
);

  in_beat_t held;

  assign s_axis_tready = !held.valid || take;
  assign beat          = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (s_axis_tready) begin
      held.valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      held.data <= s_axis_tdata;
      held.last <= s_axis_tlast;
    end
  end

endmodule

[rtl/hrp_core.sv]
`include "assert_macros.svh"

module hrp_core
  import hrp_pkg::*;
#(
  parameter int MAX_HEADERS = DEF_MAX_HEADERS,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_beat_t beat,
  output logic     res_load,
  output result_t  res
);

  localparam int BW  = $clog2(MAX_LENGTH + 1);
  localparam int HW  = $clog2(MAX_HEADERS + 1);
  localparam int XW  = (BW > 13) ? BW : 13;
  localparam logic [BW-1:0] LEN_LIMIT = BW'(MAX_LENGTH);
  localparam logic [HW-1:0] HDR_LIMIT = HW'(MAX_HEADERS);

  phase_t        phase, phase_next;
  logic [BW-1:0] byte_position, byte_position_next;
  logic [6:0]    cands, cands_next;
  logic [2:0]    tok_len, tok_len_next;
  logic [BW-1:0] line_start, line_start_next;
  logic [BW-1:0] last_space, last_space_next;
  logic          last_space_valid, last_space_valid_next;
  logic          prev_cr, prev_cr_next;
  logic [HW-1:0] headers_seen, headers_seen_next;
  logic [3:0]    acc_matched, acc_matched_next;
  logic          acc_found, acc_found_next;
  saved_t        saved, saved_next;

  logic [7:0]    b;
  logic [XW-1:0] pos_x, ls_x, sp_x;
  logic [2:0]    code;
  status_t       st;

  assign b     = beat.data;
  assign pos_x = XW'(byte_position);
  assign ls_x  = XW'(line_start);
  assign sp_x  = XW'(last_space);

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    cands_next            = cands;
    tok_len_next          = tok_len;
    line_start_next       = line_start;
    last_space_next       = last_space;
    last_space_valid_next = last_space_valid;
    prev_cr_next          = prev_cr;
    headers_seen_next     = headers_seen;
    acc_matched_next      = acc_matched;
    acc_found_next        = acc_found;
    saved_next            = saved;
    code                  = M_NONE;

    // first surviving method whose full name fits in the token
    for (int k = 0; k < 7; k++) begin
      if (code == M_NONE && cands[k] && tok_len >= METHOD_LEN[k]) begin
        code = 3'(k + 1);
      end
    end

    if (byte_position >= LEN_LIMIT) begin
      saved_next.status = ST_LONG;
      phase_next        = PH_CLOSED;
    end else begin
      byte_position_next = byte_position + 1'b1;
      case (phase)
        PH_METHOD: begin
          if (b == CH_NUL) begin
            saved_next.status = ST_METHOD;
            phase_next        = PH_CLOSED;
          end else if (b == CH_SP) begin
            if (code == M_NONE) begin
              saved_next.status = ST_METHOD;
              phase_next        = PH_CLOSED;
            end else begin
              saved_next.method     = code;
              phase_next            = PH_LINE;
              line_start_next       = byte_position + 1'b1;
              prev_cr_next          = 1'b0;
              last_space_valid_next = 1'b0;
            end
          end else begin
            for (int k = 0; k < 7; k++) begin
              if (tok_len < METHOD_LEN[k] && b != METHOD_CHARS[k][tok_len]) begin
                cands_next[k] = 1'b0;
              end
            end
            if (tok_len < TOK_SAT) begin
              tok_len_next = tok_len + 1'b1;
            end
          end
        end
        PH_LINE: begin
          if (b == CH_NUL) begin
            saved_next.status = ST_CRLF;
            phase_next        = PH_CLOSED;
          end else if (b == CH_LF && prev_cr) begin
            saved_next.uri_start = ls_x[11:0];
            if (last_space_valid) begin
              saved_next.ver_present = 1'b1;
              saved_next.ver_start   = 12'(sp_x + 1'b1);
              saved_next.ver_len     = 13'(pos_x - sp_x - 2'd2);
              saved_next.uri_len     = 13'(sp_x - ls_x);
            end else begin
              saved_next.uri_len = 13'(pos_x - ls_x - 1'b1);
            end
            phase_next       = PH_HEADERS;
            line_start_next  = byte_position + 1'b1;
            acc_matched_next = '0;
            prev_cr_next     = 1'b0;
          end else begin
            if (b == CH_SP) begin
              last_space_next       = byte_position;
              last_space_valid_next = 1'b1;
            end
            prev_cr_next = (b == CH_CR);
          end
        end
        PH_HEADERS: begin
          if (b == CH_NUL) begin
            phase_next = PH_CLOSED;
          end else if (b == CH_LF && prev_cr) begin
            if (headers_seen < HDR_LIMIT) begin
              headers_seen_next = headers_seen + 1'b1;
              if (!acc_found && acc_matched == ACC_DONE) begin
                acc_found_next       = 1'b1;
                saved_next.acc_start = 12'(ls_x + 4'd8);
                saved_next.acc_len   = 13'(pos_x - ls_x - 4'd9);
              end
            end
            line_start_next  = byte_position + 1'b1;
            acc_matched_next = '0;
            prev_cr_next     = 1'b0;
          end else begin
            if (acc_matched < ACC_DONE) begin
              if (b == ACCEPT_CHARS[acc_matched[2:0]]) begin
                acc_matched_next = acc_matched + 1'b1;
              end else begin
                acc_matched_next = ACC_FAIL;
              end
            end
            prev_cr_next = (b == CH_CR);
          end
        end
        default: begin
        end
      endcase
    end

    // summary for the final byte, taken from the state after this byte
    st = saved_next.status;
    if (st == ST_OK && phase_next == PH_METHOD) begin
      st = ST_METHOD;
    end else if (st == ST_OK && phase_next == PH_LINE) begin
      st = ST_CRLF;
    end
    res        = '0;
    res.status = st;
    if (st == ST_OK || st == ST_CRLF) begin
      res.method_code = saved_next.method;
    end
    if (st == ST_OK) begin
      res.uri_start       = saved_next.uri_start;
      res.uri_length      = saved_next.uri_len;
      res.version_present = saved_next.ver_present;
      res.version_start   = saved_next.ver_start;
      res.version_length  = saved_next.ver_len;
      res.header_count    = 5'(headers_seen_next);
      res.accept_present  = acc_found_next;
      res.accept_start    = saved_next.acc_start;
      res.accept_length   = saved_next.acc_len;
    end
  end

  assign res_load = fire && beat.last;

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase            <= PH_METHOD;
      byte_position    <= '0;
      cands            <= '1;
      tok_len          <= '0;
      line_start       <= '0;
      last_space       <= '0;
      last_space_valid <= 1'b0;
      prev_cr          <= 1'b0;
      headers_seen     <= '0;
      acc_matched      <= '0;
      acc_found        <= 1'b0;
      saved            <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      cands            <= cands_next;
      tok_len          <= tok_len_next;
      line_start       <= line_start_next;
      last_space       <= last_space_next;
      last_space_valid <= last_space_valid_next;
      prev_cr          <= prev_cr_next;
      headers_seen     <= headers_seen_next;
      acc_matched      <= acc_matched_next;
      acc_found        <= acc_found_next;
      saved            <= saved_next;
    end
  end

  `HRP_ASSERT(a_hdr_cap, clk, rst, headers_seen <= HDR_LIMIT, "header count past limit")
  `HRP_ASSERT(a_acc_hdr, clk, rst, !acc_found || headers_seen != '0, "accept without header")
  `HRP_ASSERT_NEXT(a_clear, clk, rst, res_load, byte_position == '0 && phase == PH_METHOD, "state not cleared after final byte")

endmodule

[rtl/hrp_out_reg.sv]
module hrp_out_reg
  import hrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             res,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RES_BITS-1:0] m_axis_tdata
);

  logic    valid;
  result_t held;

  assign free          = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {1'b0, held.accept_length, held.accept_start, held.accept_present,
                          held.header_count, held.version_length, held.version_start,
                          held.version_present, held.uri_length, held.uri_start,
                          held.method_code, held.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

endmodule

[rtl/http_request_parser.sv]
// http request line and header parser
// input channel s_axis: one request byte per beat in tdata, tlast on the
//   final byte of the buffer; bytes after MAX_LENGTH are dropped and flag
//   the too-long status
// output channel m_axis: one summary beat per buffer, sent for the beat
//   carrying tlast; no beat for any other byte
// pipeline: input register, one pass of parse logic, result register; the
//   summary is loaded into the result register as the final byte leaves
//   the input register, held back only while an unsent beat is waiting
// throughput: one byte per cycle, as the parse core updates its state per
//   byte, unless a final byte waits; back-to-back buffers run without gaps
// stalls: the result register holds its beat while m_axis_tready is low;
//   ordinary bytes keep flowing, and only a final byte waits in the input
//   register until the result register frees up; while it waits,
//   s_axis_tready is low
// reset: synchronous, clears both valid flags and the parse state, so the
//   next byte is taken as offset zero of a new buffer
module http_request_parser
  import hrp_pkg::*;
#(
  parameter int MAX_HEADERS = DEF_MAX_HEADERS,
  parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // final_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [4:2] method_code, [16:5] uri_start, [29:17] uri_length,
  // [30] version_present, [42:31] version_start, [55:43] version_length,
  // [60:56] header_count, [61] accept_present, [73:62] accept_start,
  // [86:74] accept_length, [87] zero
  output logic [RES_BITS-1:0] m_axis_tdata
);

  in_beat_t beat;
  logic     advance;
  logic     out_free;
  logic     res_load;
  result_t  res;

  // a held byte moves on unless it closes a buffer and the result slot is busy
  assign advance = beat.valid && (!beat.last || out_free);

  hrp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take          (advance),
    .beat          (beat)
  );

  hrp_core #(
    .MAX_HEADERS (MAX_HEADERS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .beat     (beat),
    .res_load (res_load),
    .res      (res)
  );

  hrp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_load),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
